### sv/memory_request_queue_core_defines.svh
// Assertion macros for the memory request queue core.
// Clocked on clk and disabled while arst_n is low; empty when SYNTH is defined.
`ifndef MEMORY_REQUEST_QUEUE_CORE_DEFINES_SVH
`define MEMORY_REQUEST_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTH
`define MRQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define MRQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define MRQ_ASSERT_NOW(lbl, ante, cons)
`define MRQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/mrq_pkg.sv
// Shared types and codes of the memory request queue core.
// No dependencies.
package mrq_pkg;

	typedef struct packed {
		logic [15:0] tag;
		logic [3:0]  requestor;
		logic [3:0]  bank;
		logic [31:0] arrive_time;
		logic        is_write;
	} entry_t;

	localparam int SLOT_IDX_MAX_W = 6;

	typedef struct packed {
		logic                      alloc;
		logic                      inc;
		logic                      dec;
		logic [SLOT_IDX_MAX_W-1:0] slot;
		logic [3:0]                owner;
	} slot_upd_t;

	typedef enum logic [1:0] {
		MEM_GEN,
		MEM_SLOT,
		MEM_WR
	} mem_sel_t;

	localparam logic [3:0] OP_INSERT   = 4'd0;
	localparam logic [3:0] OP_SEL_GEN  = 4'd1;
	localparam logic [3:0] OP_SEL_SLOT = 4'd2;
	localparam logic [3:0] OP_PEEK_GEN = 4'd3;
	localparam logic [3:0] OP_PEEK_SLOT = 4'd4;
	localparam logic [3:0] OP_REMOVE   = 4'd5;
	localparam logic [3:0] OP_EARLIEST = 4'd6;
	localparam logic [3:0] OP_SIZE     = 4'd7;
	localparam logic [3:0] OP_DRAIN    = 4'd8;
	localparam logic [3:0] OP_WR_PEEK  = 4'd9;
	localparam logic [3:0] OP_WR_REMOVE = 4'd10;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [1:0] CFG_PER_REQ = 2'd0;
	localparam logic [1:0] CFG_WR_QUEUE = 2'd1;
	localparam logic [1:0] CFG_HWM     = 2'd2;

	localparam logic [5:0] HWM_RESET = 6'd20;

endpackage

### sv/mrq_slot_map.sv
// Requestor slot map: owner table, slot count and per-slot fill counts.
// Depends on mrq_pkg.
module mrq_slot_map #(
	parameter int SLOTS = 16,
	parameter int SLOT_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        requestor,
	input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] fill_slot,
	input  mrq_pkg::slot_upd_t upd,
	output logic              hit,
	output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] hit_slot,
	output logic [$clog2(SLOTS+1)-1:0] owners,
	output logic [$clog2(SLOT_DEPTH+1)-1:0] fill
);
	localparam int SL_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int OA_W = $clog2(SLOTS+1);
	localparam int SF_W = $clog2(SLOT_DEPTH+1);

	logic [3:0]      owner_q [SLOTS];
	logic [SF_W-1:0] fill_q [SLOTS];
	logic [OA_W-1:0] owners_q;
	logic [SL_W-1:0] upd_slot;

	assign upd_slot = upd.slot[SL_W-1:0];
	assign owners = owners_q;
	assign fill = fill_q[fill_slot];

	always_comb begin
		hit = 1'b0;
		hit_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (OA_W'(i) < owners_q && owner_q[i] == requestor) begin
				hit = 1'b1;
				hit_slot = SL_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owners_q <= '0;
			for (int i = 0; i < SLOTS; i++)
				fill_q[i] <= '0;
		end else begin
			if (upd.alloc) begin
				owners_q <= owners_q + 1'b1;
			end
			if (upd.inc)
				fill_q[upd_slot] <= fill_q[upd_slot] + 1'b1;
			else if (upd.dec)
				fill_q[upd_slot] <= fill_q[upd_slot] - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.alloc)
			owner_q[owners_q[SL_W-1:0]] <= upd.owner;
	end

endmodule

### sv/memory_request_queue_core.sv
// Top level of the memory request queue core: sequencer and entry memories.
// Depends on mrq_pkg, mrq_slot_map and memory_request_queue_core_defines.svh.
//
// Usage: one request beat enters on in_valid/in_stall (op plus request
// fields); exactly one result beat leaves on out_valid/out_stall per request.
// Configuration writes use cfg_valid/cfg_ready (cfg_ready is always high),
// cfg_index 0 per-requestor mode, 1 write-queue mode, 2 high watermark; write
// only while idle.
// Sequence: size, drain and insert ops pass from exec straight to emit;
// select, peek and write-FIFO ops that read an entry add a read-wait state.
// Remove and earliest search stream through one synchronous memory port, one
// entry per cycle: remove from the picked position up to the fill, the search
// over the whole general queue. The sequencer returns to idle when the result
// is loaded, and only then takes the next request.
// One request is in work at a time; in_stall stays high from acceptance until
// its result is loaded into the output register. A stalled result holds the
// output register and the sequencer until out_stall drops.
// Reset clears all fills, the slot map, the drain flag and the pick; the
// entry memories are not cleared and need no clearing pass.
`include "memory_request_queue_core_defines.svh"
module memory_request_queue_core #(
	parameter int GENERAL_DEPTH = 32,
	parameter int SLOTS = 16,
	parameter int SLOT_DEPTH = 32,
	parameter int WRITE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  op,
	input  logic [15:0] tag,
	input  logic [3:0]  requestor,
	input  logic [3:0]  bank,
	input  logic [31:0] arrive_time,
	input  logic        is_write,
	input  logic [3:0]  queue_slot,
	input  logic [4:0]  position,
	input  logic        size_of_slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_tag,
	output logic [3:0]  out_requestor,
	output logic [3:0]  out_bank,
	output logic [31:0] out_arrive_time,
	output logic        out_is_write,
	output logic [5:0]  count,
	output logic [4:0]  slots_used,
	output logic        reads_allowed
);
	localparam int SL_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int OA_W = $clog2(SLOTS+1);
	localparam int GF_W = $clog2(GENERAL_DEPTH+1);
	localparam int SF_W = $clog2(SLOT_DEPTH+1);
	localparam int WF_W = $clog2(WRITE_DEPTH+1);
	localparam int GA_W = $clog2(GENERAL_DEPTH);
	localparam int SA_W = $clog2(SLOTS*SLOT_DEPTH);
	localparam int WA_W = $clog2(WRITE_DEPTH);
	localparam int AW = (GA_W > SA_W) ? ((GA_W > WA_W) ? GA_W : WA_W)
		: ((SA_W > WA_W) ? SA_W : WA_W);
	localparam int MAX_DEPTH = (GENERAL_DEPTH > SLOT_DEPTH)
		? ((GENERAL_DEPTH > WRITE_DEPTH) ? GENERAL_DEPTH : WRITE_DEPTH)
		: ((SLOT_DEPTH > WRITE_DEPTH) ? SLOT_DEPTH : WRITE_DEPTH);
	localparam int IDX_W = $clog2(MAX_DEPTH+1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SHIFT,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic       per_req_q;
	logic       wr_queue_q;
	logic [5:0] hwm_q;

	logic [3:0]  op_q;
	logic [3:0]  qs_q;
	logic [4:0]  pos_q;
	logic        size_slot_q;
	mrq_pkg::entry_t req_q;

	logic [GF_W-1:0] gfill_q;
	logic [WF_W-1:0] wfill_q;
	logic [WA_W-1:0] whead_q;
	logic            draining_q;
	logic            pick_valid_q;
	logic            pick_in_slot_q;
	logic [SL_W-1:0] pick_slot_q;
	logic [4:0]      pick_pos_q;

	mrq_pkg::mem_sel_t sel_q;
	logic [AW-1:0]    base_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] end_q;
	logic             pend_s1;
	logic             first_s1;
	logic [IDX_W-1:0] wr_idx_s1;
	logic             found_q;
	mrq_pkg::entry_t  best_q;

	logic [1:0]      res_status_q;
	mrq_pkg::entry_t res_entry_q;
	logic [5:0]      res_count_q;
	logic            res_reads_q;

	logic            out_valid_q;
	mrq_pkg::entry_t out_entry_q;
	logic [1:0]      out_status_q;
	logic [5:0]      out_count_q;
	logic [4:0]      out_slots_q;
	logic            out_reads_q;
	logic            out_load;

	mrq_pkg::entry_t gen_mem [GENERAL_DEPTH];
	mrq_pkg::entry_t slot_mem [SLOTS*SLOT_DEPTH];
	mrq_pkg::entry_t wr_mem [WRITE_DEPTH];
	mrq_pkg::entry_t gen_rd_q;
	mrq_pkg::entry_t slot_rd_q;
	mrq_pkg::entry_t wr_rd_q;
	mrq_pkg::entry_t rdata;

	mrq_pkg::mem_sel_t mem_sel;
	logic              mem_we;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	mrq_pkg::entry_t   wdata;
	mrq_pkg::slot_upd_t upd;

	logic            map_hit;
	logic [SL_W-1:0] map_hit_slot;
	logic [OA_W-1:0] owners;
	logic [SF_W-1:0] sf;
	logic [SL_W-1:0] ins_slot;
	logic [SL_W-1:0] fill_slot;
	logic            wq_insert;
	logic            slot_ins_ok;
	logic            qs_bad;
	logic            in_fire;
	logic [WF_W:0]   wsum;
	logic [WA_W-1:0] wtail;
	logic            scan_match;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign in_fire = in_valid && !in_stall;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign ins_slot = map_hit ? map_hit_slot : owners[SL_W-1:0];
	assign fill_slot = (op_q == mrq_pkg::OP_INSERT) ? ins_slot
		: (op_q == mrq_pkg::OP_REMOVE) ? pick_slot_q : SL_W'(qs_q);
	assign wq_insert = wr_queue_q && req_q.is_write;
	assign slot_ins_ok = (map_hit || owners < OA_W'(SLOTS)) && sf < SF_W'(SLOT_DEPTH);
	assign qs_bad = ({1'b0, qs_q} >= 5'(owners)) || (32'(qs_q) >= SLOTS);
	assign wsum = (WF_W+1)'(whead_q) + (WF_W+1)'(wfill_q);
	assign wtail = (wsum >= (WF_W+1)'(WRITE_DEPTH)) ? WA_W'(wsum - (WF_W+1)'(WRITE_DEPTH))
		: WA_W'(wsum);
	assign scan_match = rdata.requestor == req_q.requestor && rdata.bank == req_q.bank;

	mrq_slot_map #(
		.SLOTS(SLOTS),
		.SLOT_DEPTH(SLOT_DEPTH)
	) u_map (
		.clk(clk),
		.arst_n(arst_n),
		.requestor(req_q.requestor),
		.fill_slot(fill_slot),
		.upd(upd),
		.hit(map_hit),
		.hit_slot(map_hit_slot),
		.owners(owners),
		.fill(sf)
	);

	always_comb begin
		case (sel_q)
			mrq_pkg::MEM_GEN:  rdata = gen_rd_q;
			mrq_pkg::MEM_SLOT: rdata = slot_rd_q;
			default:           rdata = wr_rd_q;
		endcase
	end

	always_comb begin
		mem_sel = sel_q;
		mem_we = 1'b0;
		raddr = AW'(base_q + AW'(rd_idx_q));
		waddr = AW'(base_q + AW'(wr_idx_s1));
		wdata = rdata;
		upd = '0;
		if (state_q == ST_EXEC) begin
			wdata = req_q;
			case (op_q)
				mrq_pkg::OP_INSERT: begin
					if (wq_insert) begin
						mem_sel = mrq_pkg::MEM_WR;
						mem_we = wfill_q < WF_W'(WRITE_DEPTH);
						waddr = AW'(wtail);
					end else if (per_req_q) begin
						mem_sel = mrq_pkg::MEM_SLOT;
						mem_we = slot_ins_ok;
						waddr = AW'(ins_slot * SLOT_DEPTH + sf);
						upd.alloc = slot_ins_ok && !map_hit;
						upd.inc = slot_ins_ok;
						upd.slot = mrq_pkg::SLOT_IDX_MAX_W'(ins_slot);
						upd.owner = req_q.requestor;
					end else begin
						mem_sel = mrq_pkg::MEM_GEN;
						mem_we = gfill_q < GF_W'(GENERAL_DEPTH);
						waddr = AW'(gfill_q);
					end
				end
				mrq_pkg::OP_SEL_GEN, mrq_pkg::OP_PEEK_GEN: begin
					mem_sel = mrq_pkg::MEM_GEN;
					raddr = AW'(pos_q);
				end
				mrq_pkg::OP_SEL_SLOT, mrq_pkg::OP_PEEK_SLOT: begin
					mem_sel = mrq_pkg::MEM_SLOT;
					raddr = AW'(SL_W'(qs_q) * SLOT_DEPTH + pos_q);
				end
				mrq_pkg::OP_REMOVE: begin
					mem_sel = pick_in_slot_q ? mrq_pkg::MEM_SLOT : mrq_pkg::MEM_GEN;
					upd.dec = pick_valid_q && pick_in_slot_q && (pick_pos_q < sf);
					upd.slot = mrq_pkg::SLOT_IDX_MAX_W'(pick_slot_q);
				end
				mrq_pkg::OP_EARLIEST: mem_sel = mrq_pkg::MEM_GEN;
				mrq_pkg::OP_WR_PEEK, mrq_pkg::OP_WR_REMOVE: begin
					mem_sel = mrq_pkg::MEM_WR;
					raddr = AW'(whead_q);
				end
				default: mem_sel = sel_q;
			endcase
		end else if (state_q == ST_SHIFT) begin
			mem_we = pend_s1 && !first_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && mem_sel == mrq_pkg::MEM_GEN)
			gen_mem[waddr[GA_W-1:0]] <= wdata;
		gen_rd_q <= gen_mem[raddr[GA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we && mem_sel == mrq_pkg::MEM_SLOT)
			slot_mem[waddr[SA_W-1:0]] <= wdata;
		slot_rd_q <= slot_mem[raddr[SA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we && mem_sel == mrq_pkg::MEM_WR)
			wr_mem[waddr[WA_W-1:0]] <= wdata;
		wr_rd_q <= wr_mem[raddr[WA_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_req_q <= 1'b0;
			wr_queue_q <= 1'b0;
			hwm_q <= mrq_pkg::HWM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mrq_pkg::CFG_PER_REQ:  per_req_q <= cfg_data[0];
				mrq_pkg::CFG_WR_QUEUE: wr_queue_q <= cfg_data[0];
				mrq_pkg::CFG_HWM:      hwm_q <= cfg_data;
				default:               hwm_q <= hwm_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= '0;
			qs_q <= '0;
			pos_q <= '0;
			size_slot_q <= 1'b0;
			req_q <= '0;
			gfill_q <= '0;
			wfill_q <= '0;
			whead_q <= '0;
			draining_q <= 1'b0;
			pick_valid_q <= 1'b0;
			pick_in_slot_q <= 1'b0;
			pick_slot_q <= '0;
			pick_pos_q <= '0;
			sel_q <= mrq_pkg::MEM_GEN;
			base_q <= '0;
			rd_idx_q <= '0;
			end_q <= '0;
			pend_s1 <= 1'b0;
			first_s1 <= 1'b0;
			wr_idx_s1 <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			res_status_q <= mrq_pkg::ST_OK;
			res_entry_q <= '0;
			res_count_q <= '0;
			res_reads_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_entry_q <= '0;
			out_status_q <= mrq_pkg::ST_OK;
			out_count_q <= '0;
			out_slots_q <= '0;
			out_reads_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q <= op;
						qs_q <= queue_slot;
						pos_q <= position;
						size_slot_q <= size_of_slot;
						req_q <= '{tag: tag, requestor: requestor, bank: bank,
							arrive_time: arrive_time, is_write: is_write};
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					sel_q <= mem_sel;
					res_entry_q <= '0;
					res_reads_q <= 1'b0;
					res_status_q <= mrq_pkg::ST_OK;
					res_count_q <= '0;
					pend_s1 <= 1'b0;
					found_q <= 1'b0;
					state_q <= ST_EMIT;
					case (op_q)
						mrq_pkg::OP_INSERT: begin
							if (wq_insert) begin
								if (wfill_q < WF_W'(WRITE_DEPTH)) begin
									wfill_q <= wfill_q + 1'b1;
									res_count_q <= 6'(wfill_q + 1'b1);
								end else begin
									res_status_q <= mrq_pkg::ST_FULL;
									res_count_q <= 6'(wfill_q);
								end
							end else if (per_req_q) begin
								if (!map_hit && owners >= OA_W'(SLOTS)) begin
									res_status_q <= mrq_pkg::ST_FULL;
								end else if (slot_ins_ok) begin
									res_count_q <= 6'(sf + 1'b1);
								end else begin
									res_status_q <= mrq_pkg::ST_FULL;
									res_count_q <= 6'(sf);
								end
							end else begin
								if (gfill_q < GF_W'(GENERAL_DEPTH)) begin
									gfill_q <= gfill_q + 1'b1;
									res_count_q <= 6'(gfill_q + 1'b1);
								end else begin
									res_status_q <= mrq_pkg::ST_FULL;
									res_count_q <= 6'(gfill_q);
								end
							end
						end
						mrq_pkg::OP_SEL_GEN, mrq_pkg::OP_PEEK_GEN: begin
							if (gfill_q == '0) begin
								res_status_q <= mrq_pkg::ST_EMPTY;
							end else if ((GF_W+5)'(pos_q) >= (GF_W+5)'(gfill_q)) begin
								res_status_q <= mrq_pkg::ST_RANGE;
								res_count_q <= 6'(gfill_q);
							end else begin
								res_count_q <= 6'(gfill_q);
								if (op_q == mrq_pkg::OP_SEL_GEN) begin
									pick_valid_q <= 1'b1;
									pick_in_slot_q <= 1'b0;
									pick_slot_q <= '0;
									pick_pos_q <= pos_q;
								end
								state_q <= ST_RDWAIT;
							end
						end
						mrq_pkg::OP_SEL_SLOT, mrq_pkg::OP_PEEK_SLOT: begin
							if (qs_bad) begin
								res_status_q <= mrq_pkg::ST_RANGE;
							end else if (sf == '0) begin
								res_status_q <= mrq_pkg::ST_EMPTY;
							end else if ((SF_W+5)'(pos_q) >= (SF_W+5)'(sf)) begin
								res_status_q <= mrq_pkg::ST_RANGE;
								res_count_q <= 6'(sf);
							end else begin
								res_count_q <= 6'(sf);
								if (op_q == mrq_pkg::OP_SEL_SLOT) begin
									pick_valid_q <= 1'b1;
									pick_in_slot_q <= 1'b1;
									pick_slot_q <= SL_W'(qs_q);
									pick_pos_q <= pos_q;
								end
								state_q <= ST_RDWAIT;
							end
						end
						mrq_pkg::OP_REMOVE: begin
							rd_idx_q <= IDX_W'(pick_pos_q);
							if (!pick_valid_q) begin
								res_status_q <= mrq_pkg::ST_EMPTY;
							end else if (pick_in_slot_q) begin
								if ((SF_W+5)'(pick_pos_q) >= (SF_W+5)'(sf)) begin
									res_status_q <= mrq_pkg::ST_RANGE;
									res_count_q <= 6'(sf);
								end else begin
									base_q <= AW'(pick_slot_q * SLOT_DEPTH);
									end_q <= IDX_W'(sf);
									res_count_q <= 6'(sf - 1'b1);
									state_q <= ST_SHIFT;
								end
							end else begin
								if ((GF_W+5)'(pick_pos_q) >= (GF_W+5)'(gfill_q)) begin
									res_status_q <= mrq_pkg::ST_RANGE;
									res_count_q <= 6'(gfill_q);
								end else begin
									base_q <= '0;
									end_q <= IDX_W'(gfill_q);
									gfill_q <= gfill_q - 1'b1;
									res_count_q <= 6'(gfill_q - 1'b1);
									state_q <= ST_SHIFT;
								end
							end
						end
						mrq_pkg::OP_EARLIEST: begin
							res_count_q <= 6'(gfill_q);
							if (gfill_q == '0) begin
								res_status_q <= mrq_pkg::ST_EMPTY;
							end else begin
								base_q <= '0;
								rd_idx_q <= '0;
								end_q <= IDX_W'(gfill_q);
								state_q <= ST_SCAN;
							end
						end
						mrq_pkg::OP_SIZE: begin
							if (!size_slot_q)
								res_count_q <= 6'(gfill_q);
							else if (owners == '0)
								res_count_q <= '0;
							else if (qs_bad)
								res_status_q <= mrq_pkg::ST_RANGE;
							else
								res_count_q <= 6'(sf);
						end
						mrq_pkg::OP_DRAIN: begin
							res_count_q <= 6'(wfill_q);
							if (draining_q) begin
								if (wfill_q == '0) begin
									draining_q <= 1'b0;
									res_reads_q <= 1'b1;
								end
							end else if ((WF_W+6)'(wfill_q) >= (WF_W+6)'(hwm_q)) begin
								draining_q <= 1'b1;
							end else begin
								res_reads_q <= 1'b1;
							end
						end
						mrq_pkg::OP_WR_PEEK, mrq_pkg::OP_WR_REMOVE: begin
							if (wfill_q == '0) begin
								res_status_q <= mrq_pkg::ST_EMPTY;
							end else begin
								state_q <= ST_RDWAIT;
								if (op_q == mrq_pkg::OP_WR_REMOVE) begin
									res_count_q <= 6'(wfill_q - 1'b1);
									wfill_q <= wfill_q - 1'b1;
									whead_q <= (whead_q == WA_W'(WRITE_DEPTH - 1)) ? '0
										: whead_q + 1'b1;
								end else begin
									res_count_q <= 6'(wfill_q);
								end
							end
						end
						default: res_status_q <= mrq_pkg::ST_RANGE;
					endcase
				end
				ST_RDWAIT: begin
					res_entry_q <= rdata;
					state_q <= ST_EMIT;
				end
				ST_SHIFT: begin
					if (rd_idx_q < end_q) begin
						pend_s1 <= 1'b1;
						first_s1 <= (rd_idx_q == IDX_W'(pick_pos_q));
						wr_idx_s1 <= rd_idx_q - 1'b1;
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && first_s1)
						res_entry_q <= rdata;
					if (!pend_s1 && rd_idx_q >= end_q)
						state_q <= ST_EMIT;
				end
				ST_SCAN: begin
					if (rd_idx_q < end_q) begin
						pend_s1 <= 1'b1;
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && scan_match
						&& (!found_q || rdata.arrive_time < best_q.arrive_time)) begin
						found_q <= 1'b1;
						best_q <= rdata;
					end
					if (!pend_s1 && rd_idx_q >= end_q) begin
						res_status_q <= found_q ? mrq_pkg::ST_OK : mrq_pkg::ST_EMPTY;
						res_entry_q <= found_q ? best_q : '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_status_q <= res_status_q;
						out_entry_q <= res_entry_q;
						out_count_q <= res_count_q;
						out_slots_q <= 5'(owners);
						out_reads_q <= res_reads_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign out_tag = out_entry_q.tag;
	assign out_requestor = out_entry_q.requestor;
	assign out_bank = out_entry_q.bank;
	assign out_arrive_time = out_entry_q.arrive_time;
	assign out_is_write = out_entry_q.is_write;
	assign count = out_count_q;
	assign slots_used = out_slots_q;
	assign reads_allowed = out_reads_q;

	`MRQ_ASSERT_NOW(a_gen_fill_bound, 1'b1, gfill_q <= GF_W'(GENERAL_DEPTH))
	`MRQ_ASSERT_NOW(a_wr_fill_bound, 1'b1, wfill_q <= WF_W'(WRITE_DEPTH))
	`MRQ_ASSERT_NOW(a_owner_bound, 1'b1, owners <= OA_W'(SLOTS))
	`MRQ_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall)

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for memory_request_queue_core: directed and random request beats,
// each result checked field by field against a behavioral queue predictor.
// Depends on mrq_pkg and the memory_request_queue_core RTL.
module testbench;

	localparam int GDEPTH = 32;
	localparam int NSLOTS = 16;
	localparam int SDEPTH = 32;
	localparam int WDEPTH = 32;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] tag;
		logic [3:0]  requestor;
		logic [3:0]  bank;
		logic [31:0] arrive_time;
		logic        is_write;
		logic [5:0]  count;
		logic [4:0]  slots_used;
		logic        reads_allowed;
	} result_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] tag;
		logic [3:0]  requestor;
		logic [3:0]  bank;
		logic [31:0] arrive_time;
		logic        is_write;
		logic [3:0]  queue_slot;
		logic [4:0]  position;
		logic        size_of_slot;
	} request_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [5:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [3:0] op = 0;
	logic [15:0] tag = 0;
	logic [3:0] requestor = 0;
	logic [3:0] bank = 0;
	logic [31:0] arrive_time = 0;
	logic is_write = 0;
	logic [3:0] queue_slot = 0;
	logic [4:0] position = 0;
	logic size_of_slot = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	logic [15:0] out_tag;
	logic [3:0] out_requestor;
	logic [3:0] out_bank;
	logic [31:0] out_arrive_time;
	logic out_is_write;
	logic [5:0] count;
	logic [4:0] slots_used;
	logic reads_allowed;

	memory_request_queue_core DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// predictor state
	logic per_req_mode, wr_queue_mode;
	logic [5:0] hwm;
	mrq_pkg::entry_t gen_q[$];
	mrq_pkg::entry_t slot_q[NSLOTS][$];
	logic [3:0] slot_owner[NSLOTS];
	int owners;
	mrq_pkg::entry_t wr_q[$];
	logic drain_on;
	logic pick_ok, pick_slot_side;
	int pick_slot, pick_pos;

	result_t expected_results[$];
	int errors = 0;
	int cycles = 0;

	function automatic result_t make_result(logic [1:0] st, mrq_pkg::entry_t e, int has_e,
			int cnt, int reads);
		result_t r;
		r = '0;
		r.status = st;
		if (has_e != 0) begin
			r.tag = e.tag;
			r.requestor = e.requestor;
			r.bank = e.bank;
			r.arrive_time = e.arrive_time;
			r.is_write = e.is_write;
		end
		r.count = cnt[5:0];
		r.slots_used = owners[4:0];
		r.reads_allowed = reads[0];
		return r;
	endfunction

	function automatic result_t predict_queue_op(request_t q);
		mrq_pkg::entry_t e;
		int s;
		logic reads;
		e.tag = q.tag;
		e.requestor = q.requestor;
		e.bank = q.bank;
		e.arrive_time = q.arrive_time;
		e.is_write = q.is_write;
		case (q.op)
			mrq_pkg::OP_INSERT: begin
				if (wr_queue_mode && q.is_write) begin
					if (wr_q.size() >= WDEPTH)
						return make_result(mrq_pkg::ST_FULL, e, 0, wr_q.size(), 0);
					wr_q.insert(wr_q.size(), e);
					return make_result(mrq_pkg::ST_OK, e, 0, wr_q.size(), 0);
				end else if (per_req_mode) begin
					s = owners;
					for (int i = 0; i < owners; i++)
						if (slot_owner[i] == q.requestor) begin
							s = i;
							break;
						end
					if (s >= owners) begin
						if (owners >= NSLOTS) return make_result(mrq_pkg::ST_FULL, e, 0, 0, 0);
						slot_owner[s] = q.requestor;
						slot_q[s].delete();
						owners++;
					end
					if (slot_q[s].size() >= SDEPTH)
						return make_result(mrq_pkg::ST_FULL, e, 0, slot_q[s].size(), 0);
					slot_q[s].insert(slot_q[s].size(), e);
					return make_result(mrq_pkg::ST_OK, e, 0, slot_q[s].size(), 0);
				end else begin
					if (gen_q.size() >= GDEPTH)
						return make_result(mrq_pkg::ST_FULL, e, 0, gen_q.size(), 0);
					gen_q.insert(gen_q.size(), e);
					return make_result(mrq_pkg::ST_OK, e, 0, gen_q.size(), 0);
				end
			end
			mrq_pkg::OP_SEL_GEN, mrq_pkg::OP_PEEK_GEN: begin
				if (gen_q.size() == 0) return make_result(mrq_pkg::ST_EMPTY, e, 0, 0, 0);
				if (q.position >= gen_q.size())
					return make_result(mrq_pkg::ST_RANGE, e, 0, gen_q.size(), 0);
				if (q.op == mrq_pkg::OP_SEL_GEN) begin
					pick_ok = 1'b1;
					pick_slot_side = 1'b0;
					pick_slot = 0;
					pick_pos = int'(q.position);
				end
				return make_result(mrq_pkg::ST_OK, gen_q[q.position], 1, gen_q.size(), 0);
			end
			mrq_pkg::OP_SEL_SLOT, mrq_pkg::OP_PEEK_SLOT: begin
				s = int'(q.queue_slot);
				if (s >= owners) return make_result(mrq_pkg::ST_RANGE, e, 0, 0, 0);
				if (slot_q[s].size() == 0) return make_result(mrq_pkg::ST_EMPTY, e, 0, 0, 0);
				if (q.position >= slot_q[s].size())
					return make_result(mrq_pkg::ST_RANGE, e, 0, slot_q[s].size(), 0);
				if (q.op == mrq_pkg::OP_SEL_SLOT) begin
					pick_ok = 1'b1;
					pick_slot_side = 1'b1;
					pick_slot = s;
					pick_pos = int'(q.position);
				end
				return make_result(mrq_pkg::ST_OK, slot_q[s][q.position], 1,
					slot_q[s].size(), 0);
			end
			mrq_pkg::OP_REMOVE: begin
				if (!pick_ok) return make_result(mrq_pkg::ST_EMPTY, e, 0, 0, 0);
				if (pick_slot_side) begin
					if (pick_pos >= slot_q[pick_slot].size())
						return make_result(mrq_pkg::ST_RANGE, e, 0, slot_q[pick_slot].size(), 0);
					e = slot_q[pick_slot][pick_pos];
					slot_q[pick_slot].delete(pick_pos);
					return make_result(mrq_pkg::ST_OK, e, 1, slot_q[pick_slot].size(), 0);
				end
				if (pick_pos >= gen_q.size())
					return make_result(mrq_pkg::ST_RANGE, e, 0, gen_q.size(), 0);
				e = gen_q[pick_pos];
				gen_q.delete(pick_pos);
				return make_result(mrq_pkg::ST_OK, e, 1, gen_q.size(), 0);
			end
			mrq_pkg::OP_EARLIEST: begin
				s = -1;
				for (int i = 0; i < gen_q.size(); i++)
					if (gen_q[i].bank == q.bank && gen_q[i].requestor == q.requestor)
						if (s < 0 || gen_q[i].arrive_time < gen_q[s].arrive_time) s = i;
				if (s < 0) return make_result(mrq_pkg::ST_EMPTY, e, 0, gen_q.size(), 0);
				return make_result(mrq_pkg::ST_OK, gen_q[s], 1, gen_q.size(), 0);
			end
			mrq_pkg::OP_SIZE: begin
				if (!q.size_of_slot) return make_result(mrq_pkg::ST_OK, e, 0, gen_q.size(), 0);
				if (owners == 0) return make_result(mrq_pkg::ST_OK, e, 0, 0, 0);
				if (q.queue_slot >= owners) return make_result(mrq_pkg::ST_RANGE, e, 0, 0, 0);
				return make_result(mrq_pkg::ST_OK, e, 0, slot_q[q.queue_slot].size(), 0);
			end
			mrq_pkg::OP_DRAIN: begin
				if (drain_on) begin
					reads = (wr_q.size() == 0);
					if (reads) drain_on = 1'b0;
				end else begin
					reads = !(wr_q.size() >= hwm);
					if (!reads) drain_on = 1'b1;
				end
				return make_result(mrq_pkg::ST_OK, e, 0, wr_q.size(), int'(reads));
			end
			mrq_pkg::OP_WR_PEEK: begin
				if (wr_q.size() == 0) return make_result(mrq_pkg::ST_EMPTY, e, 0, 0, 0);
				return make_result(mrq_pkg::ST_OK, wr_q[0], 1, wr_q.size(), 0);
			end
			mrq_pkg::OP_WR_REMOVE: begin
				if (wr_q.size() == 0) return make_result(mrq_pkg::ST_EMPTY, e, 0, 0, 0);
				e = wr_q.pop_front();
				return make_result(mrq_pkg::ST_OK, e, 1, wr_q.size(), 0);
			end
			default: return make_result(mrq_pkg::ST_RANGE, e, 0, 0, 0);
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stall pattern
	int stall_mode = 0;
	always @(posedge clk) begin
		if ((cycles % 500) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, out_tag, out_requestor, out_bank, out_arrive_time, out_is_write,
				count, slots_used, reads_allowed};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.status != want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.tag != want.tag) begin
					$display("%0t: out_tag exp %h got %h", $time, want.tag, got.tag);
					errors++;
				end
				if (got.requestor != want.requestor) begin
					$display("%0t: out_requestor exp %0d got %0d", $time, want.requestor,
						got.requestor);
					errors++;
				end
				if (got.bank != want.bank) begin
					$display("%0t: out_bank exp %0d got %0d", $time, want.bank, got.bank);
					errors++;
				end
				if (got.arrive_time != want.arrive_time) begin
					$display("%0t: out_arrive_time exp %h got %h", $time, want.arrive_time,
						got.arrive_time);
					errors++;
				end
				if (got.is_write != want.is_write) begin
					$display("%0t: out_is_write exp %0d got %0d", $time, want.is_write,
						got.is_write);
					errors++;
				end
				if (got.count != want.count) begin
					$display("%0t: count exp %0d got %0d", $time, want.count, got.count);
					errors++;
				end
				if (got.slots_used != want.slots_used) begin
					$display("%0t: slots_used exp %0d got %0d", $time, want.slots_used,
						got.slots_used);
					errors++;
				end
				if (got.reads_allowed != want.reads_allowed) begin
					$display("%0t: reads_allowed exp %0d got %0d", $time, want.reads_allowed,
						got.reads_allowed);
					errors++;
				end
			end
		end
	end

	int burst_left = 0;

	task automatic send_request(request_t q);
		@(posedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1;
		op <= q.op;
		tag <= q.tag;
		requestor <= q.requestor;
		bank <= q.bank;
		arrive_time <= q.arrive_time;
		is_write <= q.is_write;
		queue_slot <= q.queue_slot;
		position <= q.position;
		size_of_slot <= q.size_of_slot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.insert(expected_results.size(), predict_queue_op(q));
		in_valid <= 0;
	endtask

	task automatic drain_results();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [5:0] val);
		drain_results();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			mrq_pkg::CFG_PER_REQ: per_req_mode = val[0];
			mrq_pkg::CFG_WR_QUEUE: wr_queue_mode = val[0];
			default: hwm = val;
		endcase
	endtask

	function automatic request_t random_request(logic [3:0] o);
		request_t q;
		q = '0;
		q.op = o;
		q.tag = 16'($urandom);
		q.requestor = 4'($urandom_range(0, 15));
		q.bank = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3))
			: 4'($urandom_range(0, 15));
		q.arrive_time = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 20)) : $urandom;
		q.is_write = 1'($urandom_range(0, 1));
		q.queue_slot = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(0, owners > 0 ? owners - 1 : 0));
		q.position = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 4));
		q.size_of_slot = 1'($urandom_range(0, 1));
		return q;
	endfunction

	task automatic test_directed_general();
		request_t q;
		for (int i = 0; i < 4; i++) begin
			q = random_request(mrq_pkg::OP_INSERT);
			q.requestor = (i & 1) != 0 ? 4'hF : 4'h0;
			q.bank = (i >> 1) != 0 ? 4'hF : 4'h0;
			q.tag = (i == 0) ? 16'hFFFF : 16'h0000;
			q.arrive_time = (i == 0) ? 32'hFFFF_FFFF : 32'(i);
			send_request(q);
		end
		q = random_request(mrq_pkg::OP_PEEK_GEN);
		q.position = 5'd31;
		send_request(q);
		q.op = mrq_pkg::OP_SEL_GEN;
		q.position = 5'd1;
		send_request(q);
		q.op = mrq_pkg::OP_REMOVE;
		send_request(q);
		send_request(q);
		q = random_request(mrq_pkg::OP_EARLIEST);
		q.requestor = 4'hF;
		q.bank = '0;
		send_request(q);
		q.bank = 4'h7;
		send_request(q);
		q = random_request(mrq_pkg::OP_SIZE);
		q.size_of_slot = 1'b1;
		send_request(q);
		for (int o = 11; o < 16; o++) send_request(random_request(o[3:0]));
		send_request(random_request(mrq_pkg::OP_WR_PEEK));
		send_request(random_request(mrq_pkg::OP_WR_REMOVE));
	endtask

	task automatic test_fill_to_full();
		request_t q;
		for (int i = 0; i < 34; i++) begin
			q = random_request(mrq_pkg::OP_INSERT);
			q.is_write = 1'b0;
			send_request(q);
		end
		q = random_request(mrq_pkg::OP_SEL_GEN);
		q.position = 5'd31;
		send_request(q);
		for (int i = 0; i < 33; i++) send_request(random_request(mrq_pkg::OP_REMOVE));
	endtask

	task automatic test_slots_and_writes();
		request_t q;
		write_register(mrq_pkg::CFG_PER_REQ, 6'd1);
		write_register(mrq_pkg::CFG_WR_QUEUE, 6'd1);
		write_register(mrq_pkg::CFG_HWM, 6'd1);
		for (int i = 0; i < 40; i++) begin
			q = random_request(mrq_pkg::OP_INSERT);
			q.requestor = 4'(i % 16);
			q.is_write = (i % 5 == 0);
			send_request(q);
		end
		for (int i = 0; i < 34; i++) begin
			q = random_request(mrq_pkg::OP_INSERT);
			q.is_write = 1'b1;
			send_request(q);
		end
		for (int i = 0; i < 3; i++) send_request(random_request(mrq_pkg::OP_DRAIN));
		for (int i = 0; i < 36; i++) send_request(random_request(mrq_pkg::OP_WR_REMOVE));
		send_request(random_request(mrq_pkg::OP_DRAIN));
		q = random_request(mrq_pkg::OP_SEL_SLOT);
		q.queue_slot = 4'd15;
		q.position = '0;
		send_request(q);
		send_request(random_request(mrq_pkg::OP_REMOVE));
		send_request(random_request(mrq_pkg::OP_REMOVE));
		write_register(mrq_pkg::CFG_HWM, 6'd0);
		send_request(random_request(mrq_pkg::OP_DRAIN));
		send_request(random_request(mrq_pkg::OP_DRAIN));
	endtask

	task automatic test_random_mix();
		request_t q;
		int pick;
		for (int phase = 0; phase < 4; phase++) begin
			write_register(mrq_pkg::CFG_PER_REQ, 6'($urandom_range(0, 1)));
			write_register(mrq_pkg::CFG_WR_QUEUE, 6'($urandom_range(0, 1)));
			write_register(mrq_pkg::CFG_HWM, (phase == 3) ? 6'd32 : 6'($urandom_range(1, 32)));
			for (int i = 0; i < 130; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) q = random_request(mrq_pkg::OP_INSERT);
				else if (pick < 95) q = random_request(4'($urandom_range(1, 10)));
				else q = random_request(4'($urandom_range(0, 15)));
				send_request(q);
			end
		end
		write_register(mrq_pkg::CFG_HWM, 6'd63);
		for (int i = 0; i < 80; i++) send_request(random_request(4'($urandom_range(0, 10))));
	endtask

	initial begin
		per_req_mode = 0;
		wr_queue_mode = 0;
		hwm = mrq_pkg::HWM_RESET;
		owners = 0;
		drain_on = 0;
		pick_ok = 0;
		pick_slot_side = 0;
		pick_slot = 0;
		pick_pos = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed_general();
		test_fill_to_full();
		test_slots_and_writes();
		test_random_mix();
		drain_results();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

### files.f
+incdir+sv
sv/mrq_pkg.sv
sv/mrq_slot_map.sv
sv/memory_request_queue_core.sv
tb/sv/testbench.sv
